@@ hw/rtl/nslice_coordinate_mapper_macros.svh @@
// Assertion macros for the nine-slice coordinate mapper checker.
// Depends on nothing; the using scope provides clk and rst_n.
`ifndef NSLICE_COORDINATE_MAPPER_MACROS_SVH
`define NSLICE_COORDINATE_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSCM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nscm same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NSCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nscm next-cycle check failed");

`endif

@@ hw/rtl/nscm_pkg.sv @@
// Shared constants, types and helpers for the nine-slice coordinate mapper.
// Depends on nothing; nscm_term, nscm_ctrl and the top level import it.
package nscm_pkg;

    // Table geometry and number format.
    localparam int MAX_STOPS = 16;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);
    localparam int MASK_W    = 15;
    localparam int VAL_W     = 32;
    localparam int SPAN_W    = VAL_W + 1;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int Q_W       = PROD_W - FRAC_BITS + 1;
    localparam int TERM_W    = Q_W + 1;
    localparam int ACC_W     = TERM_W + IDX_W + 1;
    localparam int CFG_IDX_W = 2;

    // Tolerance of 0.01 in the fixed-point format, rounded to nearest.
    localparam int TOL_Q = ((1 << FRAC_BITS) + 50) / 100;

    // Clamp limits of the accumulator.
    localparam logic signed [ACC_W-1:0] ACC_HI = {{(ACC_W-VAL_W){1'b0}}, 1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO = {{(ACC_W-VAL_W){1'b1}}, 1'b1, {(VAL_W-1){1'b0}}};

    // Operation codes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT   = 2'd0,
        REG_FIXED_MASK   = 2'd1,
        REG_USE_SCALE    = 2'd2,
        REG_SCALE_FACTOR = 2'd3
    } reg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_WALK,
        ST_DRAIN
    } state_t;

    // Configuration register contents.
    typedef struct packed {
        logic [4:0]        stop_count;
        logic [MASK_W-1:0] fixed_mask;
        logic              use_scale;
        logic [VAL_W-1:0]  scale_factor;
    } cfg_t;

    // One segment handed to the term unit.
    typedef struct packed {
        logic                     valid;
        logic                     fixed;
        logic signed [SPAN_W-1:0] span;
    } seg_t;

    // One finished term returned by the term unit.
    typedef struct packed {
        logic                     valid;
        logic                     pend;
        logic signed [TERM_W-1:0] value;
    } term_t;

    // One result item.
    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] mapped;
        logic                    passed_through;
        logic                    saturated;
    } result_t;

    // Fixed bit of a segment; segments past the mask are stretchable.
    function automatic logic seg_fixed(input logic [MASK_W-1:0] mask,
                                       input logic [IDX_W-1:0] seg);
        logic f;
        f = 1'b0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (int'(seg) == i)
            begin
                f = mask[i];
            end
        end
        return f;
    endfunction

endpackage

@@ hw/rtl/nscm_stop_ram.sv @@
// Generic single-write, single-read synchronous RAM holding the stop table.
// Depends on nothing; read data is registered and appears in the cycle after the read request.
module nscm_stop_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/nscm_term.sv @@
// Two-stage term unit: turns one segment span into its fixed, scaled or zero term.
// Depends on nscm_pkg for widths and the segment and term structs.
module nscm_term (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nscm_pkg::seg_t                seg_in,
    input  logic                          use_scale,
    input  logic [nscm_pkg::VAL_W-1:0]    scale_factor,
    output nscm_pkg::term_t               term_out
);
    import nscm_pkg::*;

    logic                     s1_valid_reg;
    logic                     s1_fixed_reg;
    logic                     s1_zero_reg;
    logic                     s1_neg_reg;
    logic signed [SPAN_W-1:0] s1_span_reg;
    logic [PROD_W-1:0]        s1_prod_reg;
    logic                     s2_valid_reg;
    logic signed [TERM_W-1:0] s2_term_reg;

    logic                     neg;
    logic [SPAN_W-1:0]        mag_wide;
    logic [VAL_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [Q_W-1:0]           q;
    logic signed [TERM_W-1:0] term_next;

    // Stage one: magnitude of the span times the scale factor.
    always_comb
    begin
        neg      = seg_in.span[SPAN_W-1];
        mag_wide = neg ? SPAN_W'(-seg_in.span) : SPAN_W'(seg_in.span);
        mag      = mag_wide[VAL_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(scale_factor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= seg_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_in.valid)
        begin
            s1_fixed_reg <= seg_in.fixed;
            s1_zero_reg  <= !seg_in.fixed && !use_scale;
            s1_neg_reg   <= neg;
            s1_span_reg  <= seg_in.span;
            s1_prod_reg  <= prod;
        end
    end

    // Stage two: round half away from zero, restore the sign, pick the term.
    always_comb
    begin
        q = {1'b0, s1_prod_reg[PROD_W-1:FRAC_BITS]} + Q_W'(s1_prod_reg[FRAC_BITS-1]);
        if (s1_fixed_reg)
        begin
            term_next = TERM_W'(s1_span_reg);
        end
        else if (s1_zero_reg)
        begin
            term_next = '0;
        end
        else if (s1_neg_reg)
        begin
            term_next = -$signed({1'b0, q});
        end
        else
        begin
            term_next = $signed({1'b0, q});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_term_reg <= term_next;
        end
    end

    assign term_out.valid = s2_valid_reg;
    assign term_out.pend  = s1_valid_reg;
    assign term_out.value = s2_term_reg;
endmodule

@@ hw/rtl/nscm_ctrl.sv @@
// Sequencer of the mapper: reads stops, checks tolerance, walks segments,
// accumulates terms and registers the result. Depends on nscm_pkg.
module nscm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          operation,
    input  logic signed [nscm_pkg::VAL_W-1:0] coordinate,
    input  nscm_pkg::cfg_t                cfg,
    input  logic [nscm_pkg::VAL_W-1:0]    rd_data,
    output logic                          rd_en,
    output logic [nscm_pkg::IDX_W-1:0]    rd_addr,
    output nscm_pkg::seg_t                seg_out,
    input  nscm_pkg::term_t               term_in,
    output logic                          busy,
    output nscm_pkg::result_t             result
);
    import nscm_pkg::*;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         seg_reg, seg_next;
    logic [IDX_W-1:0]         last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]         last_seg_reg, last_seg_next;
    logic signed [VAL_W-1:0]  coord_reg, coord_next;
    logic signed [VAL_W-1:0]  lo_reg, lo_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    result_t                  res_reg, res_next;

    logic                     accept_map;
    logic [CNT_W-1:0]         cnt;
    logic signed [VAL_W-1:0]  hi;
    logic signed [VAL_W+1:0]  c_w, lo_w, hi_w, tol_w;
    logic                     outside;
    logic                     found;

    // Stop count limited to the table's range.
    always_comb
    begin
        if (cfg.stop_count < 5'd2)
        begin
            cnt = CNT_W'(2);
        end
        else if (int'(cfg.stop_count) > MAX_STOPS)
        begin
            cnt = CNT_W'(MAX_STOPS);
        end
        else
        begin
            cnt = CNT_W'(cfg.stop_count);
        end
    end

    assign accept_map = start && (state_reg == ST_IDLE) && (operation == OP_MAP);
    assign busy       = (state_reg != ST_IDLE);

    // Tolerance window and segment compare on the stop being returned.
    always_comb
    begin
        hi      = $signed(rd_data);
        c_w     = (VAL_W+2)'(coord_reg);
        lo_w    = (VAL_W+2)'(lo_reg);
        hi_w    = (VAL_W+2)'(hi);
        tol_w   = (VAL_W+2)'(TOL_Q);
        outside = (c_w < lo_w - tol_w) || (c_w > hi_w + tol_w);
        found   = (coord_reg <= hi);
    end

    // Next state and outputs.
    always_comb
    begin
        state_next    = state_reg;
        seg_next      = seg_reg;
        last_idx_next = last_idx_reg;
        last_seg_next = last_seg_reg;
        coord_next    = coord_reg;
        lo_next       = lo_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        res_next.done = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        seg_out       = '0;

        if (term_in.valid)
        begin
            acc_next = acc_reg + ACC_W'(term_in.value);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_map)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    coord_next    = coordinate;
                    last_idx_next = IDX_W'(cnt - CNT_W'(1));
                    last_seg_next = IDX_W'(cnt - CNT_W'(2));
                    acc_next      = '0;
                    state_next    = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                lo_next    = hi;
                rd_en      = 1'b1;
                rd_addr    = last_idx_reg;
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                if (outside)
                begin
                    res_next.done           = 1'b1;
                    res_next.mapped         = coord_reg;
                    res_next.passed_through = 1'b1;
                    res_next.saturated      = 1'b0;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(1);
                    seg_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                seg_out.valid = 1'b1;
                seg_out.fixed = seg_fixed(cfg.fixed_mask, seg_reg);
                seg_out.span  = found ? SPAN_W'(coord_reg) - SPAN_W'(lo_reg)
                                      : SPAN_W'(hi) - SPAN_W'(lo_reg);
                lo_next       = hi;
                if (found || (seg_reg == last_seg_reg))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = IDX_W'(seg_reg + IDX_W'(2));
                    seg_next = seg_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!term_in.pend && !term_in.valid)
                begin
                    res_next.done           = 1'b1;
                    res_next.passed_through = 1'b0;
                    if (acc_reg > ACC_HI)
                    begin
                        res_next.mapped    = ACC_HI[VAL_W-1:0];
                        res_next.saturated = 1'b1;
                    end
                    else if (acc_reg < ACC_LO)
                    begin
                        res_next.mapped    = ACC_LO[VAL_W-1:0];
                        res_next.saturated = 1'b1;
                    end
                    else
                    begin
                        res_next.mapped    = acc_reg[VAL_W-1:0];
                        res_next.saturated = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        seg_reg      <= seg_next;
        last_idx_reg <= last_idx_next;
        last_seg_reg <= last_seg_next;
        coord_reg    <= coord_next;
        lo_reg       <= lo_next;
        acc_reg      <= acc_next;
    end

    assign result = res_reg;
endmodule

@@ hw/rtl/nslice_coordinate_mapper.sv @@
// Top level of the nine-slice piecewise-linear coordinate mapper.
// Depends on nscm_pkg, nscm_stop_ram, nscm_term and nscm_ctrl.
//
// Channel   Signals                                            Transfer
// input     start, busy, operation, stop_index, stop_value,    start && !busy
//           coordinate
// result    done, mapped, passed_through, saturated            done (one cycle)
// config    cfg_we, cfg_index, cfg_data                        cfg_we
//
// A stop write gives no result; busy stays low.
// A map item keeps busy high while the first and last stops are read, and done
// shows once busy falls when it passes through; else busy also covers the walk
// of k segments (k <= 15) and the drain of the term unit before done shows: the
// single read port of the stop table delivers one stop per cycle.
// Reset clears the sequencer and loads the configuration defaults; the stop table is unset.
// Results cannot be held off; the next item is taken while done shows.
module nslice_coordinate_mapper (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   operation,
    input  logic [3:0]                             stop_index,
    input  logic signed [nscm_pkg::VAL_W-1:0]      stop_value,
    input  logic signed [nscm_pkg::VAL_W-1:0]      coordinate,
    output logic                                   done,
    output logic signed [nscm_pkg::VAL_W-1:0]      mapped,
    output logic                                   passed_through,
    output logic                                   saturated,
    input  logic                                   cfg_we,
    input  logic [nscm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [nscm_pkg::VAL_W-1:0]             cfg_data
);
    import nscm_pkg::*;

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [VAL_W-1:0] rd_data;
    seg_t             seg;
    term_t            term;
    result_t          result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_count   <= 5'd2;
            cfg_reg.fixed_mask   <= 15'h5555;
            cfg_reg.use_scale    <= 1'b1;
            cfg_reg.scale_factor <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STOP_COUNT:   cfg_reg.stop_count   <= cfg_data[4:0];
                REG_FIXED_MASK:   cfg_reg.fixed_mask   <= cfg_data[MASK_W-1:0];
                REG_USE_SCALE:    cfg_reg.use_scale    <= cfg_data[0];
                REG_SCALE_FACTOR: cfg_reg.scale_factor <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Stop writes go straight to the table; slots past its depth are dropped.
    assign wr_en   = start && !busy && (operation == OP_WRITE)
                     && (int'(stop_index) < MAX_STOPS);
    assign wr_addr = IDX_W'(stop_index);

    nscm_stop_ram #(
        .DEPTH (MAX_STOPS),
        .WIDTH (VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (stop_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    nscm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .coordinate (coordinate),
        .cfg        (cfg_reg),
        .rd_data    (rd_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .seg_out    (seg),
        .term_in    (term),
        .busy       (busy),
        .result     (result)
    );

    nscm_term u_term (
        .clk          (clk),
        .rst_n        (rst_n),
        .seg_in       (seg),
        .use_scale    (cfg_reg.use_scale),
        .scale_factor (cfg_reg.scale_factor),
        .term_out     (term)
    );

    assign done           = result.done;
    assign mapped         = result.mapped;
    assign passed_through = result.passed_through;
    assign saturated      = result.saturated;
endmodule

@@ hw/rtl/nscm_checker.sv @@
// Port-level checker for the coordinate mapper, bound to the top level.
// Depends on the assertion macros header.
`include "nslice_coordinate_mapper_macros.svh"

module nscm_port_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic operation,
    input logic done,
    input logic passed_through,
    input logic saturated
);
    // A result is only shown once the sequencer has gone back to idle.
    `NSCM_ASSERT_SAME(a_done_idle, done, !busy)
    // A passed-through coordinate is never reported as clamped.
    `NSCM_ASSERT_SAME(a_pass_no_sat, done && passed_through, !saturated)
    // A map transfer occupies the block in the following cycle.
    `NSCM_ASSERT_NEXT(a_map_busy, start && !busy && operation, busy && !done)
    // A stop write finishes at once and produces no result.
    `NSCM_ASSERT_NEXT(a_write_quiet, start && !busy && !operation, !busy && !done)
endmodule

bind nslice_coordinate_mapper nscm_port_checker u_nscm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .done           (done),
    .passed_through (passed_through),
    .saturated      (saturated)
);
